[rtl/core/gstu_pkg.sv]
// ============================================================================
// gstu_pkg
// Shared types, constants and helpers for the gravity source term update.
// ============================================================================
package gstu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int RHO_W     = DATA_W - 1;        // positive density magnitude
    localparam int WIDE_W    = 2 * DATA_W;        // products and sums of squares
    localparam int QUO_W     = WIDE_W - 1;        // (sum of squares) >> 1
    localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage

    localparam int TS_W      = 31;
    localparam int ADDR_W    = 5;
    localparam int IDX_W     = 3;

    // register indexes (byte address / 4)
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRAVITY_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_GRAVITY_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_GRAVITY_Z = 3'd3;
    localparam logic [IDX_W-1:0] REG_MODE_3D   = 3'd4;

    // kinetic energy change is clamped to +/- 2^33 before the energy add
    localparam logic signed [WIDE_W-1:0] DELTA_MAX = 64'sd8589934592;
    localparam logic signed [WIDE_W-1:0] DELTA_MIN = -64'sd8589934592;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -64'sd2147483648;

    // cell fields carried through the front of the pipe
    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] e;
        logic [RHO_W-1:0]         rho;
        logic                     bad;
        logic                     d3;
    } gstu_cell_t;

    // fields carried alongside the dividers
    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] nu;
        logic signed [DATA_W-1:0] nv;
        logic signed [DATA_W-1:0] nw;
        logic                     bad;
    } gstu_side_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[DATA_W-1:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[DATA_W-1:0];
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
        logic [DATA_W-1:0] r;
        r = x[DATA_W-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

endpackage

[rtl/core/gravity_source_term_update.sv]
// ============================================================================
// gravity_source_term_update
// Uniform gravity source term on momentum and total energy, Q16.16 saturating.
// ============================================================================
// Pipeline: 6 arithmetic stages, 63 divider stages and 2 energy stages; the
//   depth is set by the bit-per-stage kinetic energy dividers.
// Throughput: one word per cycle; the whole pipe holds while the output word
//   waits.
// Reset: rst_n clears all valid bits and the configuration registers.
module gravity_source_term_update (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: density_old, density_new, momentum_x_in, momentum_y_in,
    //          momentum_z_in, energy_in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [6*gstu_pkg::DATA_W-1:0]   s_tdata,
    // m_tdata: momentum_x_out, momentum_y_out, momentum_z_out, energy_out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [4*gstu_pkg::DATA_W-1:0]   m_tdata,
    // m_tuser: bad_density
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gstu_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import gstu_pkg::*;

    // ---------------- configuration ----------------
    logic [TS_W-1:0]          time_step_reg;
    logic signed [DATA_W-1:0] gravity_x_reg, gravity_y_reg, gravity_z_reg;
    logic                     three_dim_mode_reg;
    logic [IDX_W-1:0]         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg      <= '0;
            gravity_x_reg      <= '0;
            gravity_y_reg      <= '0;
            gravity_z_reg      <= '0;
            three_dim_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx)
                REG_TIME_STEP: time_step_reg      <= pwdata[TS_W-1:0];
                REG_GRAVITY_X: gravity_x_reg      <= pwdata;
                REG_GRAVITY_Y: gravity_y_reg      <= pwdata;
                REG_GRAVITY_Z: gravity_z_reg      <= pwdata;
                REG_MODE_3D:   three_dim_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TIME_STEP: prdata = {1'b0, time_step_reg};
            REG_GRAVITY_X: prdata = gravity_x_reg;
            REG_GRAVITY_Y: prdata = gravity_y_reg;
            REG_GRAVITY_Z: prdata = gravity_z_reg;
            REG_MODE_3D:   prdata = {31'd0, three_dim_mode_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_valid_reg;
    logic div_valid;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= div_valid;
            out_valid_reg <= v7_reg;
        end
    end

    // ---------------- stage 1: gravity * dt, mean density, old squares ----------
    logic signed [DATA_W-1:0] rho_o_in, rho_n_in;
    logic signed [DATA_W:0]   rho_sum;
    gstu_cell_t               cell_in;
    logic [DATA_W-1:0]        mag_u, mag_v, mag_w;

    assign rho_o_in   = s_tdata[0*DATA_W +: DATA_W];
    assign rho_n_in   = s_tdata[1*DATA_W +: DATA_W];
    assign rho_sum    = {rho_o_in[DATA_W-1], rho_o_in} + {rho_n_in[DATA_W-1], rho_n_in};
    assign cell_in.u  = s_tdata[2*DATA_W +: DATA_W];
    assign cell_in.v  = s_tdata[3*DATA_W +: DATA_W];
    assign cell_in.w  = s_tdata[4*DATA_W +: DATA_W];
    assign cell_in.e  = s_tdata[5*DATA_W +: DATA_W];
    assign cell_in.rho = rho_n_in[RHO_W-1:0];
    assign cell_in.bad = rho_n_in[DATA_W-1] || (rho_n_in == '0);
    assign cell_in.d3  = three_dim_mode_reg;
    assign mag_u = mag32(cell_in.u);
    assign mag_v = mag32(cell_in.v);
    assign mag_w = mag32(cell_in.w);

    logic signed [WIDE_W-1:0] tgx1_reg, tgy1_reg, tgz1_reg;
    logic signed [DATA_W-1:0] mean1_reg;
    logic [WIDE_W-1:0]        sqx1_reg, sqy1_reg, sqz1_reg;
    gstu_cell_t               c1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tgx1_reg  <= $signed({{(WIDE_W-TS_W){1'b0}}, time_step_reg})
                       * $signed({{DATA_W{gravity_x_reg[DATA_W-1]}}, gravity_x_reg});
            tgy1_reg  <= $signed({{(WIDE_W-TS_W){1'b0}}, time_step_reg})
                       * $signed({{DATA_W{gravity_y_reg[DATA_W-1]}}, gravity_y_reg});
            tgz1_reg  <= $signed({{(WIDE_W-TS_W){1'b0}}, time_step_reg})
                       * $signed({{DATA_W{gravity_z_reg[DATA_W-1]}}, gravity_z_reg});
            mean1_reg <= rho_sum[DATA_W:1];
            sqx1_reg  <= {{DATA_W{1'b0}}, mag_u} * {{DATA_W{1'b0}}, mag_u};
            sqy1_reg  <= {{DATA_W{1'b0}}, mag_v} * {{DATA_W{1'b0}}, mag_v};
            sqz1_reg  <= {{DATA_W{1'b0}}, mag_w} * {{DATA_W{1'b0}}, mag_w};
            c1_reg    <= cell_in;
        end
    end

    // ---------------- stage 2: saturate dg, old sum of squares ----------------
    logic signed [DATA_W-1:0] dgx2_reg, dgy2_reg, dgz2_reg, mean2_reg;
    logic [WIDE_W-1:0]        so2_reg;
    gstu_cell_t               c2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dgx2_reg  <= sat32(tgx1_reg >>> FRAC_BITS);
            dgy2_reg  <= sat32(tgy1_reg >>> FRAC_BITS);
            dgz2_reg  <= sat32(tgz1_reg >>> FRAC_BITS);
            mean2_reg <= mean1_reg;
            so2_reg   <= sqx1_reg + sqy1_reg + (c1_reg.d3 ? sqz1_reg : '0);
            c2_reg    <= c1_reg;
        end
    end

    // ---------------- stage 3: dg * mean ----------------
    logic signed [WIDE_W-1:0] dmx3_reg, dmy3_reg, dmz3_reg;
    logic [WIDE_W-1:0]        so3_reg;
    gstu_cell_t               c3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmx3_reg <= $signed({{DATA_W{dgx2_reg[DATA_W-1]}}, dgx2_reg})
                      * $signed({{DATA_W{mean2_reg[DATA_W-1]}}, mean2_reg});
            dmy3_reg <= $signed({{DATA_W{dgy2_reg[DATA_W-1]}}, dgy2_reg})
                      * $signed({{DATA_W{mean2_reg[DATA_W-1]}}, mean2_reg});
            dmz3_reg <= $signed({{DATA_W{dgz2_reg[DATA_W-1]}}, dgz2_reg})
                      * $signed({{DATA_W{mean2_reg[DATA_W-1]}}, mean2_reg});
            so3_reg  <= so2_reg;
            c3_reg   <= c2_reg;
        end
    end

    // ---------------- stage 4: new momentum ----------------
    logic signed [DATA_W-1:0] nu4_reg, nv4_reg, nw4_reg;
    logic [WIDE_W-1:0]        so4_reg;
    gstu_cell_t               c4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nu4_reg <= sat32($signed({{DATA_W{c3_reg.u[DATA_W-1]}}, c3_reg.u})
                             + (dmx3_reg >>> FRAC_BITS));
            nv4_reg <= sat32($signed({{DATA_W{c3_reg.v[DATA_W-1]}}, c3_reg.v})
                             + (dmy3_reg >>> FRAC_BITS));
            nw4_reg <= c3_reg.d3
                     ? sat32($signed({{DATA_W{c3_reg.w[DATA_W-1]}}, c3_reg.w})
                             + (dmz3_reg >>> FRAC_BITS))
                     : c3_reg.w;
            so4_reg <= so3_reg;
            c4_reg  <= c3_reg;
        end
    end

    // ---------------- stage 5: new squares ----------------
    logic [DATA_W-1:0]        mag_nu, mag_nv, mag_nw;
    logic [WIDE_W-1:0]        sqx5_reg, sqy5_reg, sqz5_reg, so5_reg;
    logic signed [DATA_W-1:0] nu5_reg, nv5_reg, nw5_reg;
    gstu_cell_t               c5_reg;

    assign mag_nu = mag32(nu4_reg);
    assign mag_nv = mag32(nv4_reg);
    assign mag_nw = mag32(nw4_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx5_reg <= {{DATA_W{1'b0}}, mag_nu} * {{DATA_W{1'b0}}, mag_nu};
            sqy5_reg <= {{DATA_W{1'b0}}, mag_nv} * {{DATA_W{1'b0}}, mag_nv};
            sqz5_reg <= {{DATA_W{1'b0}}, mag_nw} * {{DATA_W{1'b0}}, mag_nw};
            nu5_reg  <= nu4_reg;
            nv5_reg  <= nv4_reg;
            nw5_reg  <= nw4_reg;
            so5_reg  <= so4_reg;
            c5_reg   <= c4_reg;
        end
    end

    // ---------------- stage 6: new sum of squares ----------------
    logic [WIDE_W-1:0] so6_reg, sn6_reg;
    logic [RHO_W-1:0]  rho6_reg;
    gstu_side_t        side6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn6_reg      <= sqx5_reg + sqy5_reg + (c5_reg.d3 ? sqz5_reg : '0);
            so6_reg      <= so5_reg;
            rho6_reg     <= c5_reg.rho;
            side6_reg.u  <= c5_reg.u;
            side6_reg.v  <= c5_reg.v;
            side6_reg.w  <= c5_reg.w;
            side6_reg.e  <= c5_reg.e;
            side6_reg.nu <= nu5_reg;
            side6_reg.nv <= nv5_reg;
            side6_reg.nw <= nw5_reg;
            side6_reg.bad <= c5_reg.bad;
        end
    end

    // ---------------- kinetic energy dividers ----------------
    logic [QUO_W-1:0] q_old, q_new;
    gstu_side_t       div_side;

    gstu_kediv u_kediv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (v6_reg),
        .rho      (rho6_reg),
        .num_old  (so6_reg[WIDE_W-1:1]),
        .num_new  (sn6_reg[WIDE_W-1:1]),
        .side_in  (side6_reg),
        .out_valid(div_valid),
        .q_old    (q_old),
        .q_new    (q_new),
        .side_out (div_side)
    );

    // ---------------- stage 7: clamped energy change ----------------
    logic signed [WIDE_W-1:0] delta;
    logic signed [WIDE_W-1:0] delta7_reg;
    gstu_side_t               side7_reg;

    assign delta = $signed({1'b0, q_new}) - $signed({1'b0, q_old});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (delta > DELTA_MAX)
                delta7_reg <= DELTA_MAX;
            else if (delta < DELTA_MIN)
                delta7_reg <= DELTA_MIN;
            else
                delta7_reg <= delta;
            side7_reg <= div_side;
        end
    end

    // ---------------- output word ----------------
    logic signed [DATA_W-1:0] e_new;
    logic [4*DATA_W-1:0]      tdata_reg;
    logic                     tuser_reg;

    assign e_new = sat32($signed({{DATA_W{side7_reg.e[DATA_W-1]}}, side7_reg.e}) + delta7_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tuser_reg <= side7_reg.bad;
            if (side7_reg.bad)
                tdata_reg <= {side7_reg.e, side7_reg.w, side7_reg.v, side7_reg.u};
            else
                tdata_reg <= {e_new, side7_reg.nw, side7_reg.nv, side7_reg.nu};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

[rtl/core/gstu_kediv.sv]
// ============================================================================
// gstu_kediv
// Pipelined restoring divider pair: one quotient bit per stage for the old
// and the new kinetic energy, with a common divisor and a sideband word.
// ============================================================================
module gstu_kediv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [gstu_pkg::RHO_W-1:0]   rho,
    input  logic [gstu_pkg::QUO_W-1:0]   num_old,
    input  logic [gstu_pkg::QUO_W-1:0]   num_new,
    input  gstu_pkg::gstu_side_t         side_in,
    output logic                         out_valid,
    output logic [gstu_pkg::QUO_W-1:0]   q_old,
    output logic [gstu_pkg::QUO_W-1:0]   q_new,
    output gstu_pkg::gstu_side_t         side_out
);
    import gstu_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [RHO_W-1:0]      rho_reg   [DIV_STAGES];
    logic [QUO_W-1:0]      nqo_reg   [DIV_STAGES];
    logic [QUO_W-1:0]      nqn_reg   [DIV_STAGES];
    logic [RHO_W-1:0]      remo_reg  [DIV_STAGES];
    logic [RHO_W-1:0]      remn_reg  [DIV_STAGES];
    gstu_side_t            side_reg  [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [RHO_W-1:0] rho_in;
            logic [QUO_W-1:0] nqo_in, nqn_in;
            logic [RHO_W-1:0] remo_in, remn_in;
            gstu_side_t       side_k;
            logic [RHO_W:0]   trial_o, trial_n;
            logic             qo_bit, qn_bit;

            if (k == 0)
            begin : g_first
                assign rho_in  = rho;
                assign nqo_in  = num_old;
                assign nqn_in  = num_new;
                assign remo_in = '0;
                assign remn_in = '0;
                assign side_k  = side_in;
            end
            else
            begin : g_next
                assign rho_in  = rho_reg[k-1];
                assign nqo_in  = nqo_reg[k-1];
                assign nqn_in  = nqn_reg[k-1];
                assign remo_in = remo_reg[k-1];
                assign remn_in = remn_reg[k-1];
                assign side_k  = side_reg[k-1];
            end

            // remainder stays below rho, so the shifted trial fits rho width + 1
            assign trial_o = {remo_in, nqo_in[QUO_W-1]};
            assign trial_n = {remn_in, nqn_in[QUO_W-1]};
            assign qo_bit  = (trial_o >= {1'b0, rho_in});
            assign qn_bit  = (trial_n >= {1'b0, rho_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rho_reg[k]  <= rho_in;
                    side_reg[k] <= side_k;
                    nqo_reg[k]  <= {nqo_in[QUO_W-2:0], qo_bit};
                    nqn_reg[k]  <= {nqn_in[QUO_W-2:0], qn_bit};
                    remo_reg[k] <= qo_bit ? RHO_W'(trial_o - {1'b0, rho_in})
                                          : trial_o[RHO_W-1:0];
                    remn_reg[k] <= qn_bit ? RHO_W'(trial_n - {1'b0, rho_in})
                                          : trial_n[RHO_W-1:0];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign q_old     = nqo_reg[DIV_STAGES-1];
    assign q_new     = nqn_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

[rtl/core/gstu_checker.sv]
// ============================================================================
// gstu_checker
// Port-level checks on the gravity source term update, bound to the top.
// ============================================================================
module gstu_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [4*gstu_pkg::DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);
    // a waiting output word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // the pipe never blocks input while the sink is taking words
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input blocked while output ready");

    // an empty output stage always accepts input
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no output word pending");

    // reset leaves no word on the output from the first clocked reset edge on
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind gravity_source_term_update gstu_checker u_gstu_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
